/* rtl/core/amm_pkg.sv */
// ----------------------------------------------------------------------------
// amm_pkg
// Shared types, constants and arithmetic helpers of the affine metric matrix.
// ----------------------------------------------------------------------------
package amm_pkg;

  localparam int MAX_DIM            = 4;
  localparam int ROW_COLS           = 2 * MAX_DIM;
  localparam int COORD_W            = 16;
  localparam int SUM_W              = 48;
  localparam int WORD_W             = 64;
  localparam int ACC_DEPTH          = MAX_DIM + MAX_DIM * (MAX_DIM + 1) / 2;
  localparam int ACC_AW             = $clog2(ACC_DEPTH);
  localparam int DEFAULT_MAX_POINTS = 1024;

  localparam logic [1:0] STATUS_OK       = 2'd0;
  localparam logic [1:0] STATUS_SINGULAR = 2'd1;
  localparam logic [1:0] STATUS_EMPTY    = 2'd2;

  localparam logic [1:0] CFG_DIMS   = 2'd0;
  localparam logic [1:0] CFG_THRESH = 2'd1;

  localparam logic [2:0]  DIMS_RESET   = 3'd3;
  localparam logic [15:0] THRESH_RESET = 16'd1;

  localparam logic signed [WORD_W-1:0] ONE_Q32   = 64'sh0000_0001_0000_0000;
  localparam logic signed [WORD_W-1:0] WORD_MAX  = 64'sh7FFF_FFFF_FFFF_FFFF;
  localparam logic signed [WORD_W-1:0] SUM_MAX64 = 64'sh0000_7FFF_FFFF_FFFF;
  localparam logic signed [WORD_W-1:0] SUM_MIN64 = 64'shFFFF_8000_0000_0000;

  typedef struct packed {
    logic signed [COORD_W-1:0] coord_x;
    logic signed [COORD_W-1:0] coord_y;
    logic signed [COORD_W-1:0] coord_z;
    logic signed [COORD_W-1:0] coord_w;
    logic                      final_point;
  } point_t;

  typedef struct packed {
    logic [1:0]              row_index;
    logic [1:0]              col_index;
    logic signed [SUM_W-1:0] element_value;
    logic [1:0]              status_code;
    logic                    last_element;
  } result_t;

  // request to the shared multiply-divide unit: round(a*b/c)
  typedef struct packed {
    logic                     start;
    logic signed [WORD_W-1:0] a;
    logic signed [WORD_W-1:0] b;
    logic signed [WORD_W-1:0] c;
  } md_req_t;

  typedef struct packed {
    logic        go;
    logic [1:0]  dims_last;
    logic [15:0] thr;
  } sol_cmd_t;

  function automatic logic [WORD_W-1:0] magnitude(input logic signed [WORD_W-1:0] v);
    magnitude = v[WORD_W-1] ? (~v + 64'd1) : v;
  endfunction

  function automatic logic signed [SUM_W-1:0] clamp48(input logic signed [WORD_W-1:0] v);
    if (v > SUM_MAX64)      clamp48 = SUM_MAX64[SUM_W-1:0];
    else if (v < SUM_MIN64) clamp48 = SUM_MIN64[SUM_W-1:0];
    else                    clamp48 = v[SUM_W-1:0];
  endfunction

  // coordinate pair {i, j} behind a cross-product slot
  function automatic logic [3:0] pair_coords(input logic [ACC_AW-1:0] slot);
    case (slot)
      4'd4:    pair_coords = {2'd0, 2'd0};
      4'd5:    pair_coords = {2'd0, 2'd1};
      4'd6:    pair_coords = {2'd0, 2'd2};
      4'd7:    pair_coords = {2'd0, 2'd3};
      4'd8:    pair_coords = {2'd1, 2'd1};
      4'd9:    pair_coords = {2'd1, 2'd2};
      4'd10:   pair_coords = {2'd1, 2'd3};
      4'd11:   pair_coords = {2'd2, 2'd2};
      4'd12:   pair_coords = {2'd2, 2'd3};
      4'd13:   pair_coords = {2'd3, 2'd3};
      default: pair_coords = 4'd0;
    endcase
  endfunction

  // cross-product slot of (i, j); the sums are symmetric
  function automatic logic [ACC_AW-1:0] pair_addr(input logic [1:0] i, input logic [1:0] j);
    logic [1:0] lo;
    logic [1:0] hi;
    lo = (i < j) ? i : j;
    hi = (i < j) ? j : i;
    case ({lo, hi})
      4'b00_00: pair_addr = 4'd4;
      4'b00_01: pair_addr = 4'd5;
      4'b00_10: pair_addr = 4'd6;
      4'b00_11: pair_addr = 4'd7;
      4'b01_01: pair_addr = 4'd8;
      4'b01_10: pair_addr = 4'd9;
      4'b01_11: pair_addr = 4'd10;
      4'b10_10: pair_addr = 4'd11;
      4'b10_11: pair_addr = 4'd12;
      4'b11_11: pair_addr = 4'd13;
      default:  pair_addr = 4'd4;
    endcase
  endfunction

endpackage

/* rtl/core/amm_accum.sv */
// ----------------------------------------------------------------------------
// amm_accum
// Coordinate and cross-product sums held in one small memory, updated by a
// read-modify-write sweep of one entry per cycle for each point.
// ----------------------------------------------------------------------------
module amm_accum #(
  parameter int MAX_POINTS = amm_pkg::DEFAULT_MAX_POINTS,
  parameter int CNT_W      = $clog2(MAX_POINTS + 1)
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             take,
  input  amm_pkg::point_t                  point,
  input  logic                             clear,
  output logic                             busy,
  output logic [CNT_W-1:0]                 count,
  input  logic [amm_pkg::ACC_AW-1:0]       rd_addr,
  output logic signed [amm_pkg::SUM_W-1:0] rd_data
);

  logic signed [amm_pkg::SUM_W-1:0]   acc_mem [amm_pkg::ACC_DEPTH];
  logic [amm_pkg::ACC_DEPTH-1:0]      valid;
  logic signed [amm_pkg::COORD_W-1:0] crd [amm_pkg::MAX_DIM];

  logic                               running;
  logic [amm_pkg::ACC_AW-1:0]         slot;
  logic                               wr_en;
  logic [amm_pkg::ACC_AW-1:0]         wr_addr;
  logic signed [amm_pkg::SUM_W-1:0]   addend;
  logic signed [amm_pkg::SUM_W-1:0]   addend_next;

  logic [amm_pkg::ACC_AW-1:0]         raddr;
  logic signed [amm_pkg::SUM_W-1:0]   rd_q;
  logic                               rd_vld;
  logic [3:0]                         pc;
  logic signed [2*amm_pkg::COORD_W-1:0] prod;
  logic signed [amm_pkg::WORD_W-1:0]  sum64;

  assign busy    = running | wr_en;
  assign raddr   = running ? slot : rd_addr;
  assign rd_data = rd_vld ? rd_q : '0;

  always_comb begin
    pc   = amm_pkg::pair_coords(slot);
    prod = crd[pc[3:2]] * crd[pc[1:0]];
    if (slot < amm_pkg::ACC_AW'(amm_pkg::MAX_DIM)) begin
      addend_next = amm_pkg::SUM_W'(crd[slot[1:0]]);
    end else begin
      addend_next = amm_pkg::SUM_W'(prod);
    end
    sum64 = amm_pkg::WORD_W'(rd_data) + amm_pkg::WORD_W'(addend);
  end

  always_ff @(posedge clk) begin
    rd_q   <= acc_mem[raddr];
    rd_vld <= valid[raddr];
    addend <= addend_next;
    if (wr_en) begin
      acc_mem[wr_addr] <= amm_pkg::clamp48(sum64);
    end
    if (take && count < CNT_W'(MAX_POINTS)) begin
      crd[0] <= point.coord_x;
      crd[1] <= point.coord_y;
      crd[2] <= point.coord_z;
      crd[3] <= point.coord_w;
    end
    wr_addr <= slot;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      running <= 1'b0;
      wr_en   <= 1'b0;
      slot    <= '0;
      count   <= '0;
      valid   <= '0;
    end else begin
      wr_en <= running;
      if (wr_en) begin
        valid[wr_addr] <= 1'b1;
      end
      if (take && count < CNT_W'(MAX_POINTS)) begin
        running <= 1'b1;
        slot    <= '0;
        count   <= count + 1'b1;
      end else if (running) begin
        if (slot == amm_pkg::ACC_AW'(amm_pkg::ACC_DEPTH - 1)) begin
          running <= 1'b0;
        end
        slot <= slot + 1'b1;
      end
      if (clear) begin
        valid <= '0;
        count <= '0;
      end
    end
  end

endmodule

/* rtl/core/amm_muldiv.sv */
// ----------------------------------------------------------------------------
// amm_muldiv
// Shared multiply-divide unit: round(a*b/c) half away from zero, saturated to
// +-(2^63-1). 64x64 product over four 32x32 partials, then restoring division
// one bit a cycle; a divisor of 2^32 takes the shift path.
// ----------------------------------------------------------------------------
module amm_muldiv (
  input  logic                              clk,
  input  logic                              rst,
  input  amm_pkg::md_req_t                  req,
  output logic                              done,
  output logic signed [amm_pkg::WORD_W-1:0] q
);

  typedef enum logic [1:0] {M_IDLE, M_MUL, M_DIV, M_FIN} md_state_t;

  md_state_t     state;
  logic [63:0]   ua;
  logic [63:0]   ub;
  logic [63:0]   d;
  logic          neg;
  logic          zero;
  logic          fast;
  logic [2:0]    k;
  logic [63:0]   mp;
  logic [63:0]   mp_next;
  logic [127:0]  dq;
  logic [127:0]  shifted;
  logic [127:0]  sum;
  logic [63:0]   r;
  logic [6:0]    cnt;
  logic [64:0]   rs;
  logic          ge;
  logic          rnd;
  logic          sat;
  logic [63:0]   mag;

  always_comb begin
    case (k)
      3'd0:    mp_next = 64'(ua[31:0]) * 64'(ub[31:0]);
      3'd1:    mp_next = 64'(ua[31:0]) * 64'(ub[63:32]);
      3'd2:    mp_next = 64'(ua[63:32]) * 64'(ub[31:0]);
      default: mp_next = 64'(ua[63:32]) * 64'(ub[63:32]);
    endcase
    // mp holds the partial issued in the previous cycle
    case (k)
      3'd1:    shifted = {64'd0, mp};
      3'd2:    shifted = {32'd0, mp, 32'd0};
      3'd3:    shifted = {32'd0, mp, 32'd0};
      3'd4:    shifted = {mp, 64'd0};
      default: shifted = '0;
    endcase
    sum = dq + shifted;
    rs  = {r, dq[127]};
    ge  = rs >= {1'b0, d};
    rnd = {1'b0, r} >= ({1'b0, d} - {1'b0, r});
    sat = (dq[127:63] != '0) || (rnd && (dq[62:0] == '1));
    mag = sat ? 64'(amm_pkg::WORD_MAX) : {1'b0, dq[62:0] + 63'(rnd)};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= M_IDLE;
      done  <= 1'b0;
    end else begin
      done <= 1'b0;
      unique case (state)
        M_IDLE: begin
          if (req.start) begin
            ua    <= amm_pkg::magnitude(req.a);
            ub    <= amm_pkg::magnitude(req.b);
            d     <= amm_pkg::magnitude(req.c);
            neg   <= req.a[63] ^ req.b[63] ^ req.c[63];
            zero  <= (req.c == '0);
            fast  <= (amm_pkg::magnitude(req.c) == 64'(amm_pkg::ONE_Q32));
            dq    <= '0;
            k     <= '0;
            state <= M_MUL;
          end
        end
        M_MUL: begin
          mp <= mp_next;
          k  <= k + 3'd1;
          if (k == 3'd4) begin
            cnt <= '0;
            if (fast) begin
              dq    <= {32'd0, sum[127:32]};
              r     <= {32'd0, sum[31:0]};
              state <= M_FIN;
            end else begin
              dq    <= sum;
              r     <= '0;
              state <= M_DIV;
            end
          end else begin
            dq <= sum;
          end
        end
        M_DIV: begin
          r   <= ge ? 64'(rs - {1'b0, d}) : rs[63:0];
          dq  <= {dq[126:0], ge};
          cnt <= cnt + 7'd1;
          if (cnt == '1) begin
            state <= M_FIN;
          end
        end
        M_FIN: begin
          q     <= zero ? '0 : (neg ? -$signed(mag) : $signed(mag));
          done  <= 1'b1;
          state <= M_IDLE;
        end
        default: state <= M_IDLE;
      endcase
    end
  end

endmodule

/* rtl/core/amm_solver.sv */
// ----------------------------------------------------------------------------
// amm_solver
// Builds the augmented scatter matrix in the work memory, inverts it by
// Gauss-Jordan elimination with partial pivoting; emits the inverse or zeros.
// ----------------------------------------------------------------------------
module amm_solver #(
  parameter int CNT_W = 11
) (
  input  logic                             clk,
  input  logic                             rst,
  input  amm_pkg::sol_cmd_t                cmd,
  input  logic [CNT_W-1:0]                 count,
  output logic [amm_pkg::ACC_AW-1:0]       acc_raddr,
  input  logic signed [amm_pkg::SUM_W-1:0] acc_rdata,
  output logic                             busy,
  output logic                             done,
  output amm_pkg::result_t                 result,
  output logic                             result_valid
);

  typedef enum logic [4:0] {
    S_IDLE,
    B_ELEM, B_RD_SI, B_RD_SJ, B_RD_X, B_MD, B_WAIT,
    P_RD, P_CMP, P_CHECK,
    W_RD_A, W_RD_B, W_WR_A, W_WR_B,
    N_RD, N_MD, N_WAIT,
    E_F, E_FL, E_PJ, E_RJ, E_X, E_WAIT,
    O_RD, O_OUT
  } sol_state_t;

  localparam logic signed [64:0] DIFF_MAX = 65'sh0_7FFF_FFFF_FFFF_FFFF;
  localparam logic signed [64:0] DIFF_MIN = 65'sh1_8000_0000_0000_0001;
  localparam logic signed [63:0] LIM      = 64'sh0000_7FFF_FFFF_FFFF;

  // work memory: 4 rows of 8 words, address {row, col}
  logic signed [63:0] wmem [amm_pkg::MAX_DIM * amm_pkg::ROW_COLS];
  logic [4:0]         raddr;
  logic [4:0]         waddr;
  logic               we;
  logic signed [63:0] wdata;
  logic signed [63:0] rdata;

  sol_state_t          state;
  logic [1:0]          dmax;
  logic [15:0]         thr;
  logic [CNT_W-1:0]    n;
  logic [1:0]          i;
  logic [2:0]          j;
  logic [1:0]          p;
  logic [1:0]          r;
  logic [1:0]          best;
  logic [1:0]          status;
  logic [63:0]         bestmag;
  logic signed [63:0]  piv;
  logic signed [63:0]  f;
  logic signed [63:0]  x;
  logic signed [63:0]  ta;
  logic signed [amm_pkg::SUM_W-1:0] a_sum;
  logic signed [amm_pkg::SUM_W-1:0] b_sum;

  amm_pkg::md_req_t   md_req;
  logic               md_done;
  logic signed [63:0] md_q;

  amm_muldiv u_muldiv (
    .clk  (clk),
    .rst  (rst),
    .req  (md_req),
    .done (md_done),
    .q    (md_q)
  );

  function automatic logic signed [63:0] sat_sub(input logic signed [63:0] a,
                                                 input logic signed [63:0] b);
    logic signed [64:0] diff;
    diff = {a[63], a} - {b[63], b};
    if (b == '0)            sat_sub = a;
    else if (diff > DIFF_MAX) sat_sub = amm_pkg::WORD_MAX;
    else if (diff < DIFF_MIN) sat_sub = -amm_pkg::WORD_MAX;
    else                    sat_sub = diff[63:0];
  endfunction

  // Q32.16 to Q32.32
  function automatic logic signed [63:0] to_q32(input logic signed [63:0] v);
    if (v > LIM)       to_q32 = amm_pkg::WORD_MAX;
    else if (v < -LIM) to_q32 = -amm_pkg::WORD_MAX;
    else               to_q32 = {v[47:0], 16'd0};
  endfunction

  assign busy = (state != S_IDLE);

  always_comb begin
    raddr     = '0;
    we        = 1'b0;
    waddr     = '0;
    wdata     = '0;
    acc_raddr = '0;
    md_req    = '0;
    case (state)
      B_ELEM: begin
        if (j > {1'b0, dmax}) begin
          we    = 1'b1;
          waddr = {i, j};
          wdata = (j == {1'b1, i}) ? amm_pkg::ONE_Q32 : '0;
        end
      end
      B_RD_SI: acc_raddr = {2'b00, i};
      B_RD_SJ: acc_raddr = {2'b00, j[1:0]};
      B_RD_X:  acc_raddr = amm_pkg::pair_addr(i, j[1:0]);
      B_MD: begin
        md_req.start = 1'b1;
        md_req.a     = 64'(a_sum);
        md_req.b     = 64'(b_sum);
        md_req.c     = $signed(64'(n));
      end
      B_WAIT: begin
        we    = md_done;
        waddr = {i, j};
        wdata = to_q32(sat_sub(x, md_q));
      end
      P_RD:   raddr = {r, 1'b0, p};
      W_RD_A: raddr = {p, j};
      W_RD_B: raddr = {best, j};
      W_WR_A: begin
        we    = 1'b1;
        waddr = {p, j};
        wdata = rdata;
      end
      W_WR_B: begin
        we    = 1'b1;
        waddr = {best, j};
        wdata = ta;
      end
      N_RD: raddr = {p, j};
      N_MD: begin
        md_req.start = 1'b1;
        md_req.a     = rdata;
        md_req.b     = amm_pkg::ONE_Q32;
        md_req.c     = piv;
      end
      N_WAIT: begin
        we    = md_done;
        waddr = {p, j};
        wdata = md_q;
      end
      E_F:  raddr = {r, 1'b0, p};
      E_PJ: raddr = {p, j};
      E_RJ: begin
        raddr        = {r, j};
        md_req.start = 1'b1;
        md_req.a     = f;
        md_req.b     = rdata;
        md_req.c     = amm_pkg::ONE_Q32;
      end
      E_WAIT: begin
        we    = md_done;
        waddr = {r, j};
        wdata = sat_sub(x, md_q);
      end
      O_RD: raddr = {i, 1'b1, j[1:0]};
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    rdata <= wmem[raddr];
    if (we) begin
      wmem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      result_valid <= 1'b0;
      done         <= 1'b0;
    end else begin
      result_valid <= 1'b0;
      done         <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (cmd.go) begin
            dmax <= cmd.dims_last;
            thr  <= cmd.thr;
            n    <= count;
            i    <= '0;
            j    <= '0;
            if (count == '0) begin
              status <= amm_pkg::STATUS_EMPTY;
              state  <= O_RD;
            end else begin
              status <= amm_pkg::STATUS_OK;
              state  <= B_ELEM;
            end
          end
        end
        B_ELEM, B_WAIT: begin
          if (state == B_ELEM && j <= {1'b0, dmax}) begin
            state <= B_RD_SI;
          end else if (state == B_ELEM || md_done) begin
            if (j == 3'd7) begin
              j <= '0;
              if (i == dmax) begin
                p     <= '0;
                r     <= '0;
                state <= P_RD;
              end else begin
                i     <= i + 2'd1;
                state <= B_ELEM;
              end
            end else begin
              j     <= j + 3'd1;
              state <= B_ELEM;
            end
          end
        end
        B_RD_SI: state <= B_RD_SJ;
        B_RD_SJ: begin
          a_sum <= acc_rdata;
          state <= B_RD_X;
        end
        B_RD_X: begin
          b_sum <= acc_rdata;
          state <= B_MD;
        end
        B_MD: begin
          x     <= 64'(acc_rdata);
          state <= B_WAIT;
        end
        P_RD: state <= P_CMP;
        P_CMP: begin
          // first row with the largest magnitude wins
          if (r == p || amm_pkg::magnitude(rdata) > bestmag) begin
            best    <= r;
            bestmag <= amm_pkg::magnitude(rdata);
            piv     <= rdata;
          end
          if (r == dmax) begin
            state <= P_CHECK;
          end else begin
            r     <= r + 2'd1;
            state <= P_RD;
          end
        end
        P_CHECK: begin
          j <= '0;
          if (bestmag <= {32'd0, thr, 16'd0}) begin
            status <= amm_pkg::STATUS_SINGULAR;
            i      <= '0;
            state  <= O_RD;
          end else if (best != p) begin
            state <= W_RD_A;
          end else begin
            state <= N_RD;
          end
        end
        W_RD_A: state <= W_RD_B;
        W_RD_B: begin
          ta    <= rdata;
          state <= W_WR_A;
        end
        W_WR_A: state <= W_WR_B;
        W_WR_B: begin
          if (j == 3'd7) begin
            j     <= '0;
            state <= N_RD;
          end else begin
            j     <= j + 3'd1;
            state <= W_RD_A;
          end
        end
        N_RD: state <= N_MD;
        N_MD: state <= N_WAIT;
        N_WAIT: begin
          if (md_done) begin
            if (j == 3'd7) begin
              j     <= '0;
              r     <= '0;
              state <= E_F;
            end else begin
              j     <= j + 3'd1;
              state <= N_RD;
            end
          end
        end
        E_F, E_WAIT: begin
          if (state == E_F && r != p) begin
            state <= E_FL;
          end else if (state == E_WAIT && !(md_done && j == 3'd7)) begin
            if (md_done) begin
              j     <= j + 3'd1;
              state <= E_PJ;
            end
          end else if (r == dmax) begin
            // pivot column done
            j <= '0;
            if (p == dmax) begin
              i     <= '0;
              state <= O_RD;
            end else begin
              p     <= p + 2'd1;
              r     <= p + 2'd1;
              state <= P_RD;
            end
          end else begin
            r     <= r + 2'd1;
            state <= E_F;
          end
        end
        E_FL: begin
          f     <= rdata;
          j     <= '0;
          state <= E_PJ;
        end
        E_PJ: state <= E_RJ;
        E_RJ: state <= E_X;
        E_X: begin
          x     <= rdata;
          state <= E_WAIT;
        end
        O_RD: state <= O_OUT;
        O_OUT: begin
          result_valid              <= 1'b1;
          result.row_index          <= i;
          result.col_index          <= j[1:0];
          result.element_value      <= (status == amm_pkg::STATUS_OK) ?
                                       amm_pkg::clamp48(rdata) : '0;
          result.status_code        <= status;
          result.last_element       <= (i == dmax) && (j[1:0] == dmax);
          state                     <= O_RD;
          if (j[1:0] == dmax) begin
            j <= '0;
            if (i == dmax) begin
              done  <= 1'b1;
              state <= S_IDLE;
            end else begin
              i <= i + 2'd1;
            end
          end else begin
            j <= j + 3'd1;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

/* rtl/core/affine_metric_matrix.sv */
// ----------------------------------------------------------------------------
// affine_metric_matrix
// Inverse of the mean-centered scatter matrix of a point set, Q16.32 out.
// ----------------------------------------------------------------------------
// A point is taken when start is high and busy is low. A point that is not the
// last one keeps busy high while the sums are updated: they live in one memory
// with a single read-modify-write path, one of its 14 entries updated per cycle.
// The last point then runs the inversion: each element product and quotient goes
// through one shared multiply-divide unit, which takes the shift path with a 2^32
// divisor and a restoring divide otherwise. The dims*dims results follow row by
// row, each on result for one cycle with result_valid; they cannot be held off.
// busy falls in the cycle after the last result shows. Configuration must be
// written only while busy is low; the block itself does not enforce it.
// ----------------------------------------------------------------------------
module affine_metric_matrix #(
  parameter int MAX_POINTS = amm_pkg::DEFAULT_MAX_POINTS
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  output logic             busy,
  input  amm_pkg::point_t  point,
  output logic             result_valid,
  output amm_pkg::result_t result,
  input  logic             cfg_valid,
  output logic             cfg_ready,
  input  logic [1:0]       cfg_index,
  input  logic [15:0]      cfg_data
);

  localparam int CNT_W = $clog2(MAX_POINTS + 1);

  typedef enum logic [1:0] {T_IDLE, T_ACCUM, T_SOLVE} top_state_t;

  top_state_t                       state;
  logic                             final_q;
  logic [2:0]                       dims_cfg;
  logic [15:0]                      thr_cfg;
  logic                             take;
  logic                             acc_busy;
  logic [CNT_W-1:0]                 count;
  logic [amm_pkg::ACC_AW-1:0]       acc_raddr;
  logic signed [amm_pkg::SUM_W-1:0] acc_rdata;
  amm_pkg::sol_cmd_t                sol_cmd;
  logic                             sol_busy;
  logic                             sol_done;

  assign cfg_ready = 1'b1;
  assign busy      = (state != T_IDLE);
  assign take      = start && !busy;

  always_comb begin
    sol_cmd.go  = (state == T_ACCUM) && !acc_busy && final_q;
    sol_cmd.thr = thr_cfg;
    if (dims_cfg == 3'd0) begin
      sol_cmd.dims_last = 2'd0;
    end else if (dims_cfg > 3'(amm_pkg::MAX_DIM)) begin
      sol_cmd.dims_last = 2'(amm_pkg::MAX_DIM - 1);
    end else begin
      sol_cmd.dims_last = 2'(dims_cfg - 3'd1);
    end
  end

  amm_accum #(
    .MAX_POINTS (MAX_POINTS),
    .CNT_W      (CNT_W)
  ) u_accum (
    .clk     (clk),
    .rst     (rst),
    .take    (take),
    .point   (point),
    .clear   (sol_done),
    .busy    (acc_busy),
    .count   (count),
    .rd_addr (acc_raddr),
    .rd_data (acc_rdata)
  );

  amm_solver #(
    .CNT_W (CNT_W)
  ) u_solver (
    .clk          (clk),
    .rst          (rst),
    .cmd          (sol_cmd),
    .count        (count),
    .acc_raddr    (acc_raddr),
    .acc_rdata    (acc_rdata),
    .busy         (sol_busy),
    .done         (sol_done),
    .result       (result),
    .result_valid (result_valid)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= T_IDLE;
      final_q  <= 1'b0;
      dims_cfg <= amm_pkg::DIMS_RESET;
      thr_cfg  <= amm_pkg::THRESH_RESET;
    end else begin
      if (cfg_valid && cfg_ready) begin
        unique case (cfg_index)
          amm_pkg::CFG_DIMS:   dims_cfg <= cfg_data[2:0];
          amm_pkg::CFG_THRESH: thr_cfg  <= cfg_data;
          default: ;
        endcase
      end
      unique case (state)
        T_IDLE: begin
          if (take) begin
            final_q <= point.final_point;
            state   <= T_ACCUM;
          end
        end
        T_ACCUM: begin
          if (!acc_busy) begin
            state <= final_q ? T_SOLVE : T_IDLE;
          end
        end
        T_SOLVE: begin
          if (sol_done) begin
            state <= T_IDLE;
          end
        end
        default: state <= T_IDLE;
      endcase
    end
  end

  // results only come out of a running computation
  a_result_in_solve: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> (busy && state == T_SOLVE))
    else $error("result word outside a computation");

  a_take_busy: assert property (@(posedge clk) disable iff (rst)
    take |=> busy)
    else $error("busy did not rise after a point was taken");

  a_last_ends: assert property (@(posedge clk) disable iff (rst)
    (result_valid && result.last_element) |=> !result_valid)
    else $error("result word after the last element");

  a_fail_zero: assert property (@(posedge clk) disable iff (rst)
    (result_valid && result.status_code != amm_pkg::STATUS_OK) |->
      (result.element_value == '0))
    else $error("nonzero element with failing status");

  a_solver_idle: assert property (@(posedge clk) disable iff (rst)
    (state == T_IDLE) |-> (!sol_busy && !acc_busy))
    else $error("datapath active while idle");

endmodule

/* tb/sv/affine_metric_matrix_tb.sv */
// ----------------------------------------------------------------------------
// affine_metric_matrix_tb
// Feeds point sets through the block and checks every inverse-scatter element
// against a bit-true predictor of the sums, the centering and the pivoted
// Gauss-Jordan inversion. Directed sets first, then random sets.
// ----------------------------------------------------------------------------
module affine_metric_matrix_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam longint I64_MAX   = 64'sh7FFF_FFFF_FFFF_FFFF;
  localparam longint S48_MAX   = 64'sh0000_7FFF_FFFF_FFFF;
  localparam longint S48_MIN   = 64'shFFFF_8000_0000_0000;
  localparam longint Q32_ONE   = 64'sh0000_0001_0000_0000;
  localparam int     PT_LIMIT  = amm_pkg::DEFAULT_MAX_POINTS;
  localparam int     CYC_LIMIT = 10000000;

  typedef struct {
    bit              set_dims;
    logic [2:0]      dims;
    amm_pkg::point_t pt;
    bit              singular;   // expectation typed in: all zero, singular status
  } dir_row_t;

  logic    clk, rst, start, busy, result_valid, cfg_valid, cfg_ready;
  amm_pkg::point_t  point;
  amm_pkg::result_t result;
  logic [1:0]  cfg_index;
  logic [15:0] cfg_data;

  affine_metric_matrix i_dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .point(point),
    .result_valid(result_valid), .result(result), .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  // predictor state
  logic [2:0]  dims_reg;
  logic [15:0] thr_reg;
  longint      coord_acc [amm_pkg::MAX_DIM];
  longint      xprod_acc [amm_pkg::MAX_DIM][amm_pkg::MAX_DIM];
  int          pts_taken;
  longint      aug [amm_pkg::MAX_DIM][amm_pkg::ROW_COLS];

  amm_pkg::result_t elem_q [$];
  int      err_cnt;
  longint  cyc;

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  function automatic longint sat48(longint v);
    if (v > S48_MAX) return S48_MAX;
    if (v < S48_MIN) return S48_MIN;
    return v;
  endfunction

  function automatic logic [63:0] mag64(longint v);
    return v < 0 ? 64'(-v) : 64'(v);
  endfunction

  function automatic longint sub_sat(longint a, longint b);
    logic signed [65:0] t;
    t = $signed({{2{a[63]}}, a}) - $signed({{2{b[63]}}, b});
    if (t > I64_MAX) return I64_MAX;
    if (t < -I64_MAX) return -I64_MAX;
    return longint'(t[63:0]);
  endfunction

  // round(a*b/c) half away from zero, saturated; 0 when c is 0
  function automatic longint scaled_quot(longint a, longint b, longint c);
    logic [127:0] prod, q, r, d;
    bit neg;
    if (c == 0) return 0;
    neg  = ((a < 0) != (b < 0)) != (c < 0);
    d    = {64'd0, mag64(c)};
    prod = {64'd0, mag64(a)} * {64'd0, mag64(b)};
    q    = prod / d;
    r    = prod % d;
    if (r >= d - r) q = q + 1;
    if (q > 128'h7FFF_FFFF_FFFF_FFFF) q = 128'h7FFF_FFFF_FFFF_FFFF;
    return neg ? -longint'(q[63:0]) : longint'(q[63:0]);
  endfunction

  function automatic logic [1:0] invert_scatter(int n_dims, longint n);
    longint lim, thr, s16, piv, f, t;
    int best;
    lim = I64_MAX >>> 16;
    thr = longint'(thr_reg) * 65536;
    for (int i = 0; i < amm_pkg::MAX_DIM; i++)
      for (int j = 0; j < amm_pkg::ROW_COLS; j++) begin
        aug[i][j] = 0;
        if (i < n_dims && j < n_dims) begin
          s16 = sub_sat(xprod_acc[i][j], scaled_quot(coord_acc[i], coord_acc[j], n));
          if (s16 > lim) aug[i][j] = I64_MAX;
          else if (s16 < -lim) aug[i][j] = -I64_MAX;
          else aug[i][j] = s16 * 65536;
        end else if (i < n_dims && j == amm_pkg::MAX_DIM + i) begin
          aug[i][j] = Q32_ONE;
        end
      end
    for (int p = 0; p < n_dims; p++) begin
      best = p;
      for (int r = p + 1; r < n_dims; r++)
        if (mag64(aug[r][p]) > mag64(aug[best][p])) best = r;
      piv = aug[best][p];
      if (mag64(piv) <= 64'(thr)) return amm_pkg::STATUS_SINGULAR;
      if (best != p)
        for (int j = 0; j < amm_pkg::ROW_COLS; j++) begin
          t = aug[p][j]; aug[p][j] = aug[best][j]; aug[best][j] = t;
        end
      for (int j = 0; j < amm_pkg::ROW_COLS; j++)
        aug[p][j] = scaled_quot(aug[p][j], Q32_ONE, piv);
      for (int r = 0; r < n_dims; r++) begin
        if (r == p) continue;
        f = aug[r][p];
        for (int j = 0; j < amm_pkg::ROW_COLS; j++)
          aug[r][j] = sub_sat(aug[r][j], scaled_quot(f, aug[p][j], Q32_ONE));
      end
    end
    return amm_pkg::STATUS_OK;
  endfunction

  // take one point into the sums; on the last point queue the inverse elements
  task automatic predict_point(amm_pkg::point_t p, bit typed_singular);
    longint c [amm_pkg::MAX_DIM];
    int n_dims;
    logic [1:0] st;
    amm_pkg::result_t e;
    if (pts_taken < PT_LIMIT) begin
      c[0] = p.coord_x; c[1] = p.coord_y; c[2] = p.coord_z; c[3] = p.coord_w;
      for (int i = 0; i < amm_pkg::MAX_DIM; i++) begin
        coord_acc[i] = sat48(coord_acc[i] + c[i]);
        for (int j = 0; j < amm_pkg::MAX_DIM; j++)
          xprod_acc[i][j] = sat48(xprod_acc[i][j] + c[i] * c[j]);
      end
      pts_taken++;
    end
    if (!p.final_point) return;
    n_dims = dims_reg == 0 ? 1 :
             (dims_reg > amm_pkg::MAX_DIM ? amm_pkg::MAX_DIM : int'(dims_reg));
    st = pts_taken == 0 ? amm_pkg::STATUS_EMPTY : invert_scatter(n_dims, pts_taken);
    for (int i = 0; i < n_dims; i++)
      for (int j = 0; j < n_dims; j++) begin
        e.row_index     = 2'(i);
        e.col_index     = 2'(j);
        e.status_code   = typed_singular ? amm_pkg::STATUS_SINGULAR : st;
        e.element_value = (e.status_code == amm_pkg::STATUS_OK) ?
                          48'(sat48(aug[i][amm_pkg::MAX_DIM + j])) : 48'd0;
        e.last_element  = (i == n_dims - 1) && (j == n_dims - 1);
        elem_q.push_back(e);
      end
    for (int i = 0; i < amm_pkg::MAX_DIM; i++) begin
      coord_acc[i] = 0;
      for (int j = 0; j < amm_pkg::MAX_DIM; j++) xprod_acc[i][j] = 0;
    end
    pts_taken = 0;
  endtask

  function automatic int pick_gap();
    int k;
    k = $urandom_range(0, 99);
    if (k < 45) return 0;
    if (k < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 60);
  endfunction

  function automatic amm_pkg::point_t mk_point(int x, int y, int z, int w, bit fin);
    amm_pkg::point_t p;
    p.coord_x = 16'(x); p.coord_y = 16'(y); p.coord_z = 16'(z); p.coord_w = 16'(w);
    p.final_point = fin;
    return p;
  endfunction

  function automatic logic [15:0] rand_coord();
    // mostly full range, some small values to reach near-singular sets
    return ($urandom_range(0, 3) == 0) ? 16'($signed($urandom_range(0, 16)) - 8)
                                       : 16'($urandom);
  endfunction

  // start stays high across back-to-back words
  task automatic send_point(amm_pkg::point_t p, int gap, bit typed_singular);
    if (gap > 0) begin
      @(negedge clk) start <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    start <= 1'b1;
    point <= p;
    do @(posedge clk); while (busy);
    predict_point(p, typed_singular);
  endtask

  task automatic drain();
    @(negedge clk) start <= 1'b0;
    while (elem_q.size() != 0 || busy) @(negedge clk);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [15:0] val);
    drain();
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    if (idx == amm_pkg::CFG_DIMS) dims_reg = val[2:0];
    else if (idx == amm_pkg::CFG_THRESH) thr_reg = val;
    @(negedge clk) cfg_valid <= 1'b0;
  endtask

  task automatic field_err(string f, longint e, longint g);
    $display("%0t ns: %s expected %0d got %0d", $time, f, e, g);
  endtask

  always @(posedge clk) begin
    amm_pkg::result_t e;
    if (!rst && result_valid) begin
      if (elem_q.size() == 0) begin
        $display("%0t ns: unexpected element row %0d col %0d value %0d",
                 $time, result.row_index, result.col_index, result.element_value);
        err_cnt++;
      end else begin
        e = elem_q.pop_front();
        if (result !== e) begin
          err_cnt++;
          if (result.row_index !== e.row_index)
            field_err("row_index", e.row_index, result.row_index);
          if (result.col_index !== e.col_index)
            field_err("col_index", e.col_index, result.col_index);
          if (result.element_value !== e.element_value)
            field_err("element_value", e.element_value, result.element_value);
          if (result.status_code !== e.status_code)
            field_err("status_code", e.status_code, result.status_code);
          if (result.last_element !== e.last_element)
            field_err("last_element", e.last_element, result.last_element);
        end
      end
    end
  end

  always @(posedge clk) begin
    cyc++;
    if (cyc > CYC_LIMIT) begin
      $display("affine_metric_matrix_tb: errors");
      $finish;
    end
  end

  initial begin
    dir_row_t rows [$];
    int n_pts;
    cyc = 0; err_cnt = 0;
    start = 1'b0; point = '0; cfg_valid = 1'b0; cfg_index = amm_pkg::CFG_DIMS;
    cfg_data = '0;
    dims_reg = amm_pkg::DIMS_RESET; thr_reg = amm_pkg::THRESH_RESET; pts_taken = 0;
    for (int i = 0; i < amm_pkg::MAX_DIM; i++) begin
      coord_acc[i] = 0;
      for (int j = 0; j < amm_pkg::MAX_DIM; j++) xprod_acc[i][j] = 0;
    end
    rst = 1'b1;
    repeat (4) @(posedge clk);
    @(negedge clk) rst = 1'b0;

    // a single point has zero scatter: singular
    rows.push_back('{0, 0, mk_point(32767, -32768, 32767, -32768, 1), 1});
    rows.push_back('{0, 0, mk_point(256, 0, 0, 0, 0), 0});
    rows.push_back('{0, 0, mk_point(0, 256, 0, 0, 0), 0});
    rows.push_back('{0, 0, mk_point(0, 0, 256, 0, 0), 0});
    rows.push_back('{0, 0, mk_point(0, 0, 0, 0, 1), 0});
    rows.push_back('{0, 0, mk_point(32767, -32768, 32767, 0, 0), 0});
    rows.push_back('{0, 0, mk_point(-32768, 32767, 32767, 0, 0), 0});
    rows.push_back('{0, 0, mk_point(-32768, -32768, -32768, 0, 0), 0});
    rows.push_back('{0, 0, mk_point(32767, 32767, -32768, 0, 1), 0});
    rows.push_back('{1, 4, mk_point(-32768, -32768, -32768, -32768, 1), 1});
    rows.push_back('{0, 0, mk_point(256, 0, 0, 0, 0), 0});
    rows.push_back('{0, 0, mk_point(0, 512, 0, 0, 0), 0});
    rows.push_back('{0, 0, mk_point(0, 0, -256, 0, 0), 0});
    rows.push_back('{0, 0, mk_point(0, 0, 0, 128, 0), 0});
    rows.push_back('{0, 0, mk_point(1, -1, 1, -1, 1), 0});
    // zero dims acts as one, above the maximum acts as the maximum
    rows.push_back('{1, 0, mk_point(1, 2, 3, 4, 0), 0});
    rows.push_back('{0, 0, mk_point(-32768, 7, 7, 7, 1), 0});
    rows.push_back('{1, 7, mk_point(100, -300, 5000, -7000, 0), 0});
    rows.push_back('{0, 0, mk_point(-200, 900, 1, 32767, 0), 0});
    rows.push_back('{0, 0, mk_point(3000, 3, -12000, 44, 0), 0});
    rows.push_back('{0, 0, mk_point(-5, 60, 70, -8000, 0), 0});
    rows.push_back('{0, 0, mk_point(11, -4000, 250, 9, 1), 0});
    rows.push_back('{1, 2, mk_point(4, 4, 0, 0, 0), 0});
    rows.push_back('{0, 0, mk_point(8, 8, 0, 0, 1), 0});
    foreach (rows[k]) begin
      if (rows[k].set_dims) write_reg(amm_pkg::CFG_DIMS, {13'd0, rows[k].dims});
      send_point(rows[k].pt, pick_gap(), rows[k].singular);
    end

    // threshold extremes: zero and the largest pivot floor
    write_reg(amm_pkg::CFG_THRESH, 16'd0);
    send_point(mk_point(1, 0, 0, 0, 0), 0, 0);
    send_point(mk_point(0, 1, 0, 0, 1), 0, 0);
    write_reg(amm_pkg::CFG_THRESH, 16'hFFFF);
    send_point(mk_point(300, 0, 0, 0, 0), 0, 0);
    send_point(mk_point(0, 300, 0, 0, 1), 0, 0);
    write_reg(amm_pkg::CFG_THRESH, 16'd1);

    // random sets, mostly well formed, with new settings between some of them
    n_pts = 0;
    while (n_pts < 100) begin
      int set_len;
      amm_pkg::point_t p;
      if ($urandom_range(0, 3) == 0) begin
        write_reg(amm_pkg::CFG_DIMS, {13'd0, 3'($urandom_range(0, 7))});
        case ($urandom_range(0, 3))
          0: write_reg(amm_pkg::CFG_THRESH, 16'd0);
          1: write_reg(amm_pkg::CFG_THRESH, 16'hFFFF);
          default: write_reg(amm_pkg::CFG_THRESH, 16'($urandom_range(0, 40)));
        endcase
      end else if ($urandom_range(0, 7) == 0) begin
        drain();
      end
      set_len = ($urandom_range(0, 9) == 0) ? 1 : $urandom_range(2, 7);
      for (int k = 0; k < set_len; k++) begin
        p.coord_x = rand_coord(); p.coord_y = rand_coord();
        p.coord_z = rand_coord(); p.coord_w = rand_coord();
        p.final_point = (k == set_len - 1);
        send_point(p, pick_gap(), 0);
        n_pts++;
      end
    end

    drain();
    repeat (20) @(posedge clk);
    if (err_cnt == 0 && elem_q.size() == 0) begin
      $display("affine_metric_matrix_tb: clean");
    end else begin
      $display("affine_metric_matrix_tb: errors");
    end
    $finish;
  end

endmodule
